@@ sv/nptc_pkg.sv @@
`default_nettype none

package nptc_pkg;

	localparam int COORD_W    = 16;
	localparam int MD_W       = 8;
	localparam int DIST_W     = MD_W + 1;
	localparam int RANGE_SQ_W = 2 * MD_W;

	localparam int NEAR_LIMIT = 127;
	localparam int NEAR_SQ_W  = 14;
	localparam logic [NEAR_SQ_W-1:0] NEAR_SQ = NEAR_SQ_W'(NEAR_LIMIT * NEAR_LIMIT);

	localparam int ROOT_W     = DIST_W;
	localparam int ROOT_IN_W  = 2 * ROOT_W;
	localparam int ROOT_REM_W = ROOT_W + 3;
	localparam int ROOT_STEPS = ROOT_W;
	localparam int ROOT_CNT_W = 4;
	localparam int ROOT_LIMIT = 257 * 257;

	localparam logic [MD_W-1:0] MAX_DISTANCE_RST = MD_W'(25);

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_QUERY  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_WALK   = 4'b0010,
		ST_ROOT   = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

endpackage

`default_nettype wire

@@ sv/nearest_point_table_core.sv @@
// Table of 2-D points with nearest-point queries.
// Items arrive on the in_valid/in_ready channel. With mode low an item appends
// its point to the table, or is dropped with status set when the table is full.
// With mode high it queries: every stored point is read from the point memory
// in insertion order, one per cycle, through a four-stage distance pipeline,
// and the smallest squared distance then goes through a nine-step integer
// square root. One result per item leaves on the out_valid/out_ready channel.
// An insert moves from IDLE to FINISH, where its result is loaded; a query
// reads its N stored points in WALK, runs the square root in ROOT when a point
// is stored and the smallest squared distance is below 257 * 257, then loads
// its result in FINISH. One item is worked on at a time: in_ready is high only
// in IDLE, which is entered again when a result is loaded.
// max_distance is written through cfg_valid/cfg_ready/cfg_data and resets to 25.
// Reset empties the table; entries are written only by inserts.
// A finished result waits in the output register while the receiver stalls;
// the next item is still taken, and its result waits until the register frees.
`default_nettype none

module nearest_point_table_core #(
	parameter int TABLE_DEPTH = 64,
	parameter int COORD_BITS  = 16
) (
	input  wire                               clk,
	input  wire                               arst_n,

	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire  [nptc_pkg::MD_W-1:0]         cfg_data,

	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire                               mode,
	input  wire  signed [nptc_pkg::COORD_W-1:0] pos_x,
	input  wire  signed [nptc_pkg::COORD_W-1:0] pos_y,

	output logic                              out_valid,
	input  wire                               out_ready,
	output logic                              status,
	output logic                              in_range,
	output logic                              found,
	output logic signed [nptc_pkg::COORD_W-1:0] nearest_x,
	output logic signed [nptc_pkg::COORD_W-1:0] nearest_y,
	output logic [nptc_pkg::DIST_W-1:0]       nearest_distance
);

	localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNTW = $clog2(TABLE_DEPTH + 1);
	localparam int CB   = COORD_BITS;
	localparam int D2W  = 2 * CB + 1;
	localparam int CW   = (D2W > nptc_pkg::ROOT_IN_W) ? D2W : nptc_pkg::ROOT_IN_W;
	localparam logic [CW-1:0] ROOT_LIMIT_W = CW'(nptc_pkg::ROOT_LIMIT);
	localparam logic [CNTW-1:0] DEPTH_CNT = CNTW'(TABLE_DEPTH);

	nptc_pkg::state_t state_q;

	logic [nptc_pkg::MD_W-1:0]       max_distance_q;
	logic [CNTW-1:0]                 count_q;
	logic [CNTW-1:0]                 n_q;
	logic [CNTW-1:0]                 rd_idx_q;
	logic                            is_query_q;
	logic                            full_q;
	logic signed [CB-1:0]            qx_q, qy_q;
	logic [nptc_pkg::RANGE_SQ_W-1:0] range_sq_q;
	logic [nptc_pkg::DIST_W-1:0]     cap_q;

	logic [2*CB-1:0] pt_mem [TABLE_DEPTH];

	logic                 rd_en;
	logic                 v_s1, v_s2, v_s3, v_s4;
	logic [2*CB-1:0]      rd_s1;
	logic signed [CB-1:0] px_s2, py_s2, px_s3, py_s3, px_s4, py_s4;
	logic [CB-1:0]        dx_s2, dy_s2;
	logic [2*CB-1:0]      sqx_s3, sqy_s3;
	logic [CW-1:0]        d2_s4;

	logic                           inr_q, found_q, any_q;
	logic [nptc_pkg::NEAR_SQ_W-1:0] best_sq_q;
	logic [CW-1:0]                  min_sq_q;
	logic signed [CB-1:0]           bx_q, by_q;
	logic [nptc_pkg::DIST_W-1:0]    dist_q;

	logic [nptc_pkg::ROOT_IN_W-1:0]  rt_n_q;
	logic [nptc_pkg::ROOT_REM_W-1:0] rt_rem_q;
	logic [nptc_pkg::ROOT_W-1:0]     rt_root_q;
	logic [nptc_pkg::ROOT_CNT_W-1:0] rt_cnt_q;

	logic                            in_xfer, ins_ok, walk_done;
	logic signed [CB-1:0]            in_x, in_y, px_s1, py_s1;
	logic signed [CB:0]              ex_d, ey_d;
	logic [CB-1:0]                   ax, ay;
	logic [nptc_pkg::ROOT_REM_W-1:0] rem_nx, trial;
	logic                            rt_take;
	logic [nptc_pkg::ROOT_W-1:0]     root_nx;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == nptc_pkg::ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign ins_ok    = in_xfer && (mode == nptc_pkg::MODE_INSERT) && (count_q != DEPTH_CNT);
	assign rd_en     = (state_q == nptc_pkg::ST_WALK) && (rd_idx_q != n_q);
	assign walk_done = (state_q == nptc_pkg::ST_WALK) && (rd_idx_q == n_q)
		&& !v_s1 && !v_s2 && !v_s3 && !v_s4;

	assign in_x  = CB'(pos_x);
	assign in_y  = CB'(pos_y);
	assign px_s1 = rd_s1[2*CB-1:CB];
	assign py_s1 = rd_s1[CB-1:0];

	always_comb begin
		ex_d = (CB+1)'(px_s1) - (CB+1)'(qx_q);
		ey_d = (CB+1)'(py_s1) - (CB+1)'(qy_q);
		ax   = ex_d[CB] ? CB'(-ex_d) : ex_d[CB-1:0];
		ay   = ey_d[CB] ? CB'(-ey_d) : ey_d[CB-1:0];
	end

	always_comb begin
		rem_nx  = {rt_rem_q[nptc_pkg::ROOT_REM_W-3:0],
			rt_n_q[nptc_pkg::ROOT_IN_W-1:nptc_pkg::ROOT_IN_W-2]};
		trial   = nptc_pkg::ROOT_REM_W'({rt_root_q, 2'b01});
		rt_take = (rem_nx >= trial);
		root_nx = {rt_root_q[nptc_pkg::ROOT_W-2:0], rt_take};
	end

	// Inserts and query walks never overlap, so reads need no forwarding.
	always_ff @(posedge clk) begin
		if (ins_ok) begin
			pt_mem[count_q[AW-1:0]] <= {in_x, in_y};
		end
		if (rd_en) begin
			rd_s1 <= pt_mem[rd_idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		px_s2  <= px_s1;
		py_s2  <= py_s1;
		dx_s2  <= ax;
		dy_s2  <= ay;
		px_s3  <= px_s2;
		py_s3  <= py_s2;
		sqx_s3 <= {CB'(0), dx_s2} * {CB'(0), dx_s2};
		sqy_s3 <= {CB'(0), dy_s2} * {CB'(0), dy_s2};
		px_s4  <= px_s3;
		py_s4  <= py_s3;
		d2_s4  <= CW'(sqx_s3) + CW'(sqy_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_distance_q <= nptc_pkg::MAX_DISTANCE_RST;
		end else if (cfg_valid && cfg_ready) begin
			max_distance_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= nptc_pkg::ST_IDLE;
			count_q    <= '0;
			rd_idx_q   <= '0;
			out_valid  <= 1'b0;
		end else begin
			if (out_valid && out_ready && (state_q != nptc_pkg::ST_FINISH)) begin
				out_valid <= 1'b0;
			end
			if (rd_en) begin
				rd_idx_q <= rd_idx_q + CNTW'(1);
			end
			case (state_q)
				nptc_pkg::ST_IDLE: begin
					if (in_xfer) begin
						rd_idx_q <= '0;
						if (mode == nptc_pkg::MODE_QUERY) begin
							state_q <= nptc_pkg::ST_WALK;
						end else begin
							state_q <= nptc_pkg::ST_FINISH;
							if (ins_ok) begin
								count_q <= count_q + CNTW'(1);
							end
						end
					end
				end
				nptc_pkg::ST_WALK: begin
					if (walk_done) begin
						if (any_q && (min_sq_q < ROOT_LIMIT_W)) begin
							state_q <= nptc_pkg::ST_ROOT;
						end else begin
							state_q <= nptc_pkg::ST_FINISH;
						end
					end
				end
				nptc_pkg::ST_ROOT: begin
					if (rt_cnt_q == '0) begin
						state_q <= nptc_pkg::ST_FINISH;
					end
				end
				nptc_pkg::ST_FINISH: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						state_q   <= nptc_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= nptc_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			is_query_q <= (mode == nptc_pkg::MODE_QUERY);
			full_q     <= (count_q == DEPTH_CNT);
			qx_q       <= in_x;
			qy_q       <= in_y;
			n_q        <= count_q;
			range_sq_q <= {nptc_pkg::MD_W'(0), max_distance_q}
				* {nptc_pkg::MD_W'(0), max_distance_q};
			cap_q      <= nptc_pkg::DIST_W'(max_distance_q) + nptc_pkg::DIST_W'(1);
			inr_q      <= 1'b0;
			found_q    <= 1'b0;
			any_q      <= 1'b0;
			best_sq_q  <= nptc_pkg::NEAR_SQ;
			bx_q       <= '0;
			by_q       <= '0;
		end else if (v_s4) begin
			if (d2_s4 < CW'(range_sq_q)) begin
				inr_q <= 1'b1;
			end
			if (d2_s4 < CW'(best_sq_q)) begin
				best_sq_q <= nptc_pkg::NEAR_SQ_W'(d2_s4);
				bx_q      <= px_s4;
				by_q      <= py_s4;
				found_q   <= 1'b1;
			end
			if (!any_q || (d2_s4 < min_sq_q)) begin
				min_sq_q <= d2_s4;
				any_q    <= 1'b1;
			end
		end

		if (walk_done) begin
			dist_q    <= cap_q;
			rt_n_q    <= nptc_pkg::ROOT_IN_W'(min_sq_q);
			rt_rem_q  <= '0;
			rt_root_q <= '0;
			rt_cnt_q  <= nptc_pkg::ROOT_CNT_W'(nptc_pkg::ROOT_STEPS - 1);
		end else if (state_q == nptc_pkg::ST_ROOT) begin
			rt_n_q    <= {rt_n_q[nptc_pkg::ROOT_IN_W-3:0], 2'b00};
			rt_rem_q  <= rt_take ? (rem_nx - trial) : rem_nx;
			rt_root_q <= root_nx;
			rt_cnt_q  <= rt_cnt_q - nptc_pkg::ROOT_CNT_W'(1);
			if ((rt_cnt_q == '0) && (root_nx < cap_q)) begin
				dist_q <= root_nx;
			end
		end

		if ((state_q == nptc_pkg::ST_FINISH) && (!out_valid || out_ready)) begin
			status           <= !is_query_q && full_q;
			in_range         <= is_query_q && inr_q;
			found            <= is_query_q && found_q;
			nearest_x        <= is_query_q ? nptc_pkg::COORD_W'(bx_q) : '0;
			nearest_y        <= is_query_q ? nptc_pkg::COORD_W'(by_q) : '0;
			nearest_distance <= is_query_q ? dist_q : '0;
		end
	end

endmodule

`default_nettype wire
